// ===== rtl/sfps_pkg.sv =====
// Shared constants and types for the servo frame parser and smoother.
package sfps_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned VAL_W  = 16;

  localparam logic [BYTE_W-1:0] CH_S     = 8'h73;
  localparam logic [BYTE_W-1:0] CH_E     = 8'h65;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  localparam logic signed [VAL_W-1:0] HOME_A = 16'sd1500;
  localparam logic signed [VAL_W-1:0] HOME_B = 16'sd1611;

  localparam logic [VAL_W-1:0] ACC_MAX = 16'hFFFF;
  localparam logic [VAL_W-1:0] POS_MAX = 16'd32767;
  localparam logic [VAL_W-1:0] NEG_MIN = 16'd32768;

  typedef struct packed {
    logic                    emit;
    logic                    push;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
  } cmd_t;

endpackage

// ===== rtl/sfps_ifs.sv =====
// Valid/ready channel interfaces for received bytes and pulse width words.
interface sfps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfps_pulse_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pulse_width_a;
  logic signed [15:0] pulse_width_b;
  logic               updated;

  modport source (output valid, output pulse_width_a, output pulse_width_b, output updated,
                  input ready);
  modport sink (input valid, input pulse_width_a, input pulse_width_b, input updated,
                output ready);
endinterface

// ===== rtl/sfps_parser.sv =====
// Frame and decimal number parser: turns accepted bytes into push and emit commands.
module sfps_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [sfps_pkg::BYTE_W-1:0]   rx_byte,
  output sfps_pkg::cmd_t                cmd
);

  typedef enum logic [1:0] {PH_SKIP, PH_SIGN, PH_DIGITS, PH_DONE} phase_t;

  localparam logic [1:0] FIELD_A    = 2'd0;
  localparam logic [1:0] FIELD_B    = 2'd1;
  localparam logic [1:0] FIELD_DONE = 2'd2;

  logic                                 in_frame, in_frame_next;
  logic [1:0]                           field, field_next;
  phase_t                               phase, phase_next;
  logic                                 neg, neg_next;
  logic [sfps_pkg::VAL_W-1:0]           acc, acc_next;
  logic signed [sfps_pkg::VAL_W-1:0]    first, first_next;
  logic                                 seen, seen_next;

  logic                                 is_digit;
  logic                                 is_ws;
  logic [19:0]                          acc_ext;
  logic [19:0]                          acc_mul;
  logic [sfps_pkg::VAL_W-1:0]           acc_sat;
  logic signed [sfps_pkg::VAL_W-1:0]    cur_val;

  always_comb begin
    is_digit = (rx_byte >= sfps_pkg::CH_ZERO) && (rx_byte <= sfps_pkg::CH_NINE);
    is_ws    = (rx_byte == sfps_pkg::CH_SPACE) ||
               ((rx_byte >= sfps_pkg::CH_TAB) && (rx_byte <= sfps_pkg::CH_CR));
    acc_ext  = 20'(acc);
    acc_mul  = (acc_ext << 3) + (acc_ext << 1) + 20'(rx_byte - sfps_pkg::CH_ZERO);
    acc_sat  = (acc_mul > 20'(sfps_pkg::ACC_MAX)) ? sfps_pkg::ACC_MAX : acc_mul[15:0];
    if (neg) begin
      cur_val = (acc >= sfps_pkg::NEG_MIN) ? 16'sh8000 : signed'(16'(~acc + 16'd1));
    end else begin
      cur_val = (acc >= sfps_pkg::POS_MAX) ? signed'(sfps_pkg::POS_MAX) : signed'(acc);
    end
  end

  always_comb begin
    in_frame_next = in_frame;
    field_next    = field;
    phase_next    = phase;
    neg_next      = neg;
    acc_next      = acc;
    first_next    = first;
    seen_next     = seen;
    cmd           = '0;
    if (fire) begin
      if (!in_frame) begin
        if (rx_byte == sfps_pkg::CH_S) begin
          in_frame_next = 1'b1;
          field_next    = FIELD_A;
          phase_next    = PH_SKIP;
          neg_next      = 1'b0;
          acc_next      = '0;
          first_next    = '0;
          seen_next     = 1'b0;
        end else if (rx_byte == sfps_pkg::CH_E) begin
          cmd.emit = 1'b1;
        end
      end else if (rx_byte != sfps_pkg::CH_E) begin
        seen_next = 1'b1;
        if (field != FIELD_DONE) begin
          if (rx_byte == sfps_pkg::CH_COMMA) begin
            if (field == FIELD_A) begin
              first_next = cur_val;
              phase_next = PH_SKIP;
              neg_next   = 1'b0;
              acc_next   = '0;
              field_next = FIELD_B;
            end else begin
              field_next = FIELD_DONE;
            end
          end else begin
            case (phase)
              PH_SKIP: begin
                if (is_ws) begin
                  phase_next = PH_SKIP;
                end else if (rx_byte == sfps_pkg::CH_PLUS || rx_byte == sfps_pkg::CH_MINUS) begin
                  neg_next   = (rx_byte == sfps_pkg::CH_MINUS);
                  phase_next = PH_SIGN;
                end else if (is_digit) begin
                  acc_next   = acc_sat;
                  phase_next = PH_DIGITS;
                end else begin
                  phase_next = PH_DONE;
                end
              end
              PH_SIGN, PH_DIGITS: begin
                if (is_digit) begin
                  acc_next   = acc_sat;
                  phase_next = PH_DIGITS;
                end else begin
                  phase_next = PH_DONE;
                end
              end
              default: begin
                phase_next = phase;
              end
            endcase
          end
        end
      end else begin
        in_frame_next = 1'b0;
        cmd.emit      = 1'b1;
        cmd.push      = seen;
        cmd.a         = (field == FIELD_A) ? cur_val : first;
        cmd.b         = cur_val;
        field_next    = FIELD_A;
        phase_next    = PH_SKIP;
        neg_next      = 1'b0;
        acc_next      = '0;
        first_next    = '0;
        seen_next     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      field    <= FIELD_A;
      phase    <= PH_SKIP;
      neg      <= 1'b0;
      acc      <= '0;
      first    <= '0;
      seen     <= 1'b0;
    end else begin
      in_frame <= in_frame_next;
      field    <= field_next;
      phase    <= phase_next;
      neg      <= neg_next;
      acc      <= acc_next;
      first    <= first_next;
      seen     <= seen_next;
    end
  end

endmodule

// ===== rtl/sfps_ring.sv =====
// Ring memory with prefetched oldest entry, running sums and the sum result stage.
module sfps_ring #(
  parameter int unsigned RING_DEPTH = 10
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       fire,
  input  sfps_pkg::cmd_t                             cmd,
  output logic                                       res_valid,
  input  logic                                       res_ready,
  output logic signed [sfps_pkg::VAL_W+$clog2(RING_DEPTH)-1:0] res_sum_a,
  output logic signed [sfps_pkg::VAL_W+$clog2(RING_DEPTH)-1:0] res_sum_b,
  output logic                                       res_updated
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned SUM_W = sfps_pkg::VAL_W + PTR_W;
  localparam int unsigned WORD_W = 2 * sfps_pkg::VAL_W;

  logic [WORD_W-1:0]              mem [RING_DEPTH];
  logic [RING_DEPTH-1:0]          filled;
  logic [PTR_W-1:0]               ptr;
  logic [PTR_W-1:0]               ptr_inc;
  logic [WORD_W-1:0]              rd_word;
  logic                           rd_hit;
  logic signed [sfps_pkg::VAL_W-1:0] old_a;
  logic signed [sfps_pkg::VAL_W-1:0] old_b;
  logic signed [SUM_W-1:0]        sum_a, sum_a_next;
  logic signed [SUM_W-1:0]        sum_b, sum_b_next;
  logic                           do_push;
  logic                           do_emit;

  always_comb begin
    ptr_inc = (ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    old_a   = rd_hit ? signed'(rd_word[WORD_W-1:sfps_pkg::VAL_W]) : sfps_pkg::HOME_A;
    old_b   = rd_hit ? signed'(rd_word[sfps_pkg::VAL_W-1:0]) : sfps_pkg::HOME_B;
    do_push = fire && cmd.push;
    do_emit = fire && cmd.emit;
    sum_a_next = sum_a;
    sum_b_next = sum_b;
    if (do_push) begin
      sum_a_next = sum_a + SUM_W'(cmd.a) - SUM_W'(old_a);
      sum_b_next = sum_b + SUM_W'(cmd.b) - SUM_W'(old_b);
    end
  end

  always_ff @(posedge clk) begin
    rd_word <= mem[ptr_inc];
    if (do_push) begin
      mem[ptr_inc] <= {cmd.a, cmd.b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_hit    <= 1'b0;
      ptr       <= '0;
      sum_a     <= SUM_W'(RING_DEPTH * 1500);
      sum_b     <= SUM_W'(RING_DEPTH * 1611);
      res_valid <= 1'b0;
    end else begin
      rd_hit <= filled[ptr_inc];
      if (do_push) begin
        filled[ptr_inc] <= 1'b1;
        ptr             <= ptr_inc;
      end
      sum_a <= sum_a_next;
      sum_b <= sum_b_next;
      if (do_emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      res_sum_a   <= sum_a_next;
      res_sum_b   <= sum_b_next;
      res_updated <= cmd.push;
    end
  end

endmodule

// ===== rtl/sfps_divide.sv =====
// Divide the two ring sums by the ring depth through a reciprocal multiply, then register the word.
module sfps_divide #(
  parameter int unsigned RING_DEPTH = 10
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic signed [sfps_pkg::VAL_W+$clog2(RING_DEPTH)-1:0] sum_a,
  input  logic signed [sfps_pkg::VAL_W+$clog2(RING_DEPTH)-1:0] sum_b,
  input  logic                                       updated,
  sfps_pulse_if.source                               pulse_chan
);

  localparam int unsigned SUM_W   = sfps_pkg::VAL_W + $clog2(RING_DEPTH);
  localparam int unsigned SHIFT   = SUM_W + $clog2(RING_DEPTH);
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam int unsigned Q_W     = PROD_W - SHIFT;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  logic [SUM_W-1:0]  mag_a;
  logic [SUM_W-1:0]  mag_b;
  logic              mid_valid;
  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_b;
  logic              neg_a;
  logic              neg_b;
  logic              mid_updated;
  logic              adv_out;
  logic              adv_mid;
  logic [Q_W-1:0]    quo_a;
  logic [Q_W-1:0]    quo_b;
  logic [Q_W-1:0]    val_a;
  logic [Q_W-1:0]    val_b;

  always_comb begin
    mag_a    = sum_a[SUM_W-1] ? SUM_W'(-sum_a) : SUM_W'(sum_a);
    mag_b    = sum_b[SUM_W-1] ? SUM_W'(-sum_b) : SUM_W'(sum_b);
    adv_out  = !pulse_chan.valid || pulse_chan.ready;
    adv_mid  = !mid_valid || adv_out;
    in_ready = adv_mid;
    quo_a    = prod_a[PROD_W-1:SHIFT];
    quo_b    = prod_b[PROD_W-1:SHIFT];
    val_a    = neg_a ? Q_W'(-quo_a) : quo_a;
    val_b    = neg_b ? Q_W'(-quo_b) : quo_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid        <= 1'b0;
      pulse_chan.valid <= 1'b0;
    end else begin
      if (adv_mid) begin
        mid_valid <= in_valid;
      end
      if (adv_out) begin
        pulse_chan.valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_mid && in_valid) begin
      prod_a      <= PROD_W'(mag_a) * PROD_W'(RECIP);
      prod_b      <= PROD_W'(mag_b) * PROD_W'(RECIP);
      neg_a       <= sum_a[SUM_W-1];
      neg_b       <= sum_b[SUM_W-1];
      mid_updated <= updated;
    end
    if (adv_out && mid_valid) begin
      pulse_chan.pulse_width_a <= signed'(val_a[sfps_pkg::VAL_W-1:0]);
      pulse_chan.pulse_width_b <= signed'(val_b[sfps_pkg::VAL_W-1:0]);
      pulse_chan.updated       <= mid_updated;
    end
  end

endmodule

// ===== rtl/servo_frame_parser_smoother_core.sv =====
// Servo frame parser with moving-average smoother: top level.
//
// byte_chan takes one received ASCII byte per word. A frame opens with 's' and
// closes with 'e'; its content holds up to two comma-separated decimal numbers.
// Each 'e' byte yields one word on pulse_chan: the truncated averages of the
// two RING_DEPTH-entry rings, and updated set when the frame pushed new values.
// Other bytes yield no word.
// Throughput: one byte per cycle, 'e' bytes included, while byte_chan.ready is high.
// After its 'e' is accepted, a result word passes through the sum update,
// reciprocal multiply and output registers.
// The ring memory is read one entry ahead of the write pointer, so the oldest
// value is ready when the next frame closes.
// Reset: rings read as 1500 and 1611 until written, sums at RING_DEPTH times those,
// parser outside a frame. No clearing pass is needed.
// Stall: up to three result words queue in the sum, multiply and output stages;
// byte_chan.ready drops only when all three hold a word and pulse_chan.ready is low.
module servo_frame_parser_smoother_core #(
  parameter int unsigned RING_DEPTH = 10
) (
  input  logic         clk,
  input  logic         rst,
  sfps_byte_if.sink    byte_chan,
  sfps_pulse_if.source pulse_chan
);

  localparam int unsigned SUM_W = sfps_pkg::VAL_W + $clog2(RING_DEPTH);

  logic                    fire;
  logic                    ring_ready;
  sfps_pkg::cmd_t          cmd;
  logic                    res_valid;
  logic                    div_ready;
  logic signed [SUM_W-1:0] res_sum_a;
  logic signed [SUM_W-1:0] res_sum_b;
  logic                    res_updated;

  assign ring_ready      = !res_valid || div_ready;
  assign byte_chan.ready = ring_ready;
  assign fire            = byte_chan.valid && ring_ready;

  sfps_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (byte_chan.rx_byte),
    .cmd     (cmd)
  );

  sfps_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .cmd         (cmd),
    .res_valid   (res_valid),
    .res_ready   (div_ready),
    .res_sum_a   (res_sum_a),
    .res_sum_b   (res_sum_b),
    .res_updated (res_updated)
  );

  sfps_divide #(
    .RING_DEPTH (RING_DEPTH)
  ) u_divide (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (res_valid),
    .in_ready   (div_ready),
    .sum_a      (res_sum_a),
    .sum_b      (res_sum_b),
    .updated    (res_updated),
    .pulse_chan (pulse_chan)
  );

endmodule

// ===== tb/servo_frame_parser_smoother_core_test.sv =====
// Self-checking testbench for the servo frame parser and moving-average smoother core.
module servo_frame_parser_smoother_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 10;
  localparam int unsigned RANDOM_BYTES = 1000;
  localparam int unsigned LIMIT = 200000;
  localparam int unsigned HOLD_FROM = 300;
  localparam int unsigned HOLD_TO = 600;
  localparam int unsigned CALM_FROM = 800;
  localparam int unsigned CALM_TO = 1100;

  localparam logic [sfps_pkg::BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [sfps_pkg::BYTE_W-1:0] CH_VT = 8'h0B;
  localparam logic [sfps_pkg::BYTE_W-1:0] CH_FF = 8'h0C;

  typedef enum int {PH_SKIP, PH_SIGN, PH_DIGITS, PH_DONE} num_phase_t;

  typedef struct {
    logic signed [sfps_pkg::VAL_W-1:0] width_a;
    logic signed [sfps_pkg::VAL_W-1:0] width_b;
    logic                              updated;
  } pulse_word_t;

  class pulse_scoreboard_t;
    bit          in_frame;
    int          field_no;
    num_phase_t  phase;
    bit          neg;
    int unsigned mag;
    int          first_val;
    bit          seen;
    int          ring_a[DEPTH];
    int          ring_b[DEPTH];
    int          ptr;
    int          sum_a;
    int          sum_b;
    pulse_word_t pending_q[$];
    int          errors;
    int          words;
    int          pushes;

    function new();
      in_frame = 1'b0;
      start_frame();
      foreach (ring_a[i]) begin
        ring_a[i] = int'(sfps_pkg::HOME_A);
        ring_b[i] = int'(sfps_pkg::HOME_B);
      end
      ptr = 0;
      sum_a = int'(DEPTH) * int'(sfps_pkg::HOME_A);
      sum_b = int'(DEPTH) * int'(sfps_pkg::HOME_B);
      errors = 0;
      words = 0;
      pushes = 0;
    endfunction

    function void clear_number();
      phase = PH_SKIP;
      neg = 1'b0;
      mag = 0;
    endfunction

    function void start_frame();
      field_no = 0;
      clear_number();
      first_val = 0;
      seen = 1'b0;
    endfunction

    function int number_value();
      if (neg) begin
        return (mag >= 32'(sfps_pkg::NEG_MIN)) ? -32768 : -int'(mag);
      end
      return (mag >= 32'(sfps_pkg::POS_MAX)) ? 32767 : int'(mag);
    endfunction

    function void parse(logic [sfps_pkg::BYTE_W-1:0] c);
      bit digit;
      digit = (c >= sfps_pkg::CH_ZERO) && (c <= sfps_pkg::CH_NINE);
      if (field_no >= 2) return;
      if (c == sfps_pkg::CH_COMMA) begin
        if (field_no == 0) begin
          first_val = number_value();
          clear_number();
          field_no = 1;
        end else begin
          field_no = 2;
        end
        return;
      end
      if (phase == PH_SKIP) begin
        if (c == sfps_pkg::CH_SPACE || (c >= sfps_pkg::CH_TAB && c <= sfps_pkg::CH_CR)) return;
        if (c == sfps_pkg::CH_PLUS || c == sfps_pkg::CH_MINUS) begin
          neg = (c == sfps_pkg::CH_MINUS);
          phase = PH_SIGN;
          return;
        end
        phase = PH_DIGITS;
      end
      if (phase != PH_DONE) begin
        if (digit) begin
          mag = mag * 10 + 32'(c - sfps_pkg::CH_ZERO);
          if (mag > 32'(sfps_pkg::ACC_MAX)) mag = 32'(sfps_pkg::ACC_MAX);
          phase = PH_DIGITS;
        end else begin
          phase = PH_DONE;
        end
      end
    endfunction

    function void push_values(int a, int b);
      ptr = (ptr + 1) % DEPTH;
      sum_a += a - ring_a[ptr];
      sum_b += b - ring_b[ptr];
      ring_a[ptr] = a;
      ring_b[ptr] = b;
    endfunction

    function void note_byte(logic [sfps_pkg::BYTE_W-1:0] c);
      pulse_word_t w;
      int cur;
      w.updated = 1'b0;
      if (!in_frame) begin
        if (c == sfps_pkg::CH_S) begin
          in_frame = 1'b1;
          start_frame();
          return;
        end
        if (c != sfps_pkg::CH_E) return;
      end else if (c != sfps_pkg::CH_E) begin
        seen = 1'b1;
        parse(c);
        return;
      end else begin
        in_frame = 1'b0;
        if (seen) begin
          cur = number_value();
          if (field_no == 0) push_values(cur, cur);
          else push_values(first_val, cur);
          w.updated = 1'b1;
        end
        start_frame();
      end
      w.width_a = sfps_pkg::VAL_W'(sum_a / int'(DEPTH));
      w.width_b = sfps_pkg::VAL_W'(sum_b / int'(DEPTH));
      pending_q.push_back(w);
    endfunction

    function void check_word(logic signed [sfps_pkg::VAL_W-1:0] a,
                             logic signed [sfps_pkg::VAL_W-1:0] b,
                             logic upd);
      pulse_word_t w;
      if (pending_q.size() == 0) begin
        $error("unexpected pulse word: a %0d b %0d updated %0b", a, b, upd);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      words++;
      if (w.updated) pushes++;
      if (a !== w.width_a) begin
        $error("pulse_width_a: expected %0d, got %0d", w.width_a, a);
        errors++;
      end
      if (b !== w.width_b) begin
        $error("pulse_width_b: expected %0d, got %0d", w.width_b, b);
        errors++;
      end
      if (upd !== w.updated) begin
        $error("updated: expected %0b, got %0b", w.updated, upd);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfps_byte_if  byte_if ();
  sfps_pulse_if pulse_if ();

  servo_frame_parser_smoother_core #(
    .RING_DEPTH(DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_chan  (byte_if),
    .pulse_chan (pulse_if)
  );

  pulse_scoreboard_t sb = new();

  logic [sfps_pkg::BYTE_W-1:0] ws_set [6] = '{sfps_pkg::CH_SPACE, sfps_pkg::CH_TAB, CH_LF,
                                              CH_VT, CH_FF, sfps_pkg::CH_CR};
  logic [sfps_pkg::BYTE_W-1:0] frame_q[$];
  int unsigned                 n_bytes = 0;
  int unsigned                 rx_cycles = 0;
  bit                          calm_in = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_byte(input logic [sfps_pkg::BYTE_W-1:0] b);
    while (!calm_in && $urandom_range(99) < 18) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid   <= 1'b1;
    byte_if.rx_byte <= b;
    do @(posedge clk); while (!byte_if.ready);
    sb.note_byte(b);
    n_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_queued();
    while (frame_q.size() != 0) send_byte(frame_q.pop_front());
  endtask

  task automatic add_noise(input int n);
    repeat (n) frame_q.push_back(sfps_pkg::BYTE_W'($urandom_range(255)));
  endtask

  task automatic add_number();
    int n_dig;
    int pick;
    logic [sfps_pkg::BYTE_W-1:0] junk;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) frame_q.push_back(ws_set[3'($urandom_range(5))]);
    end
    pick = $urandom_range(7);
    if (pick == 0) frame_q.push_back(sfps_pkg::CH_PLUS);
    else if (pick <= 2) frame_q.push_back(sfps_pkg::CH_MINUS);
    pick = $urandom_range(19);
    if (pick == 0) n_dig = 0;
    else if (pick <= 2) n_dig = $urandom_range(5, 7);
    else n_dig = $urandom_range(1, 4);
    repeat (n_dig) begin
      frame_q.push_back(sfps_pkg::BYTE_W'(sfps_pkg::CH_ZERO + $urandom_range(9)));
    end
    if ($urandom_range(9) == 0) begin
      junk = sfps_pkg::BYTE_W'($urandom_range(255));
      frame_q.push_back((junk == sfps_pkg::CH_E) ? sfps_pkg::CH_SPACE : junk);
    end
  endtask

  task automatic add_frame(input bit with_open, input bit with_close);
    if (with_open) frame_q.push_back(sfps_pkg::CH_S);
    add_number();
    if ($urandom_range(4) != 0) begin
      frame_q.push_back(sfps_pkg::CH_COMMA);
      add_number();
      if ($urandom_range(9) == 0) begin
        frame_q.push_back(sfps_pkg::CH_COMMA);
        add_number();
      end
    end
    if (with_close) frame_q.push_back(sfps_pkg::CH_E);
  endtask

  initial begin
    pulse_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      calm_in = (rx_cycles >= CALM_FROM) && (rx_cycles < CALM_TO);
      if (!rst && pulse_if.valid && pulse_if.ready) begin
        sb.check_word(pulse_if.pulse_width_a, pulse_if.pulse_width_b, pulse_if.updated);
      end
      if (rx_cycles >= HOLD_FROM && rx_cycles < HOLD_TO) pulse_if.ready <= 1'b0;
      else if (rx_cycles >= CALM_FROM && rx_cycles < CALM_TO) pulse_if.ready <= 1'b1;
      else pulse_if.ready <= ($urandom_range(99) >= 18);
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned start_bytes;
    int pick;
    byte_if.valid   <= 1'b0;
    byte_if.rx_byte <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("e");
    send_text("se");
    send_text("s\t-7,99999e");
    send_text("s\015-40000,+,5e");
    send_text("ss42e");

    start_bytes = n_bytes;
    while (n_bytes - start_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 85) add_frame(1'b1, 1'b1);
      else if (pick < 93) add_noise($urandom_range(1, 4));
      else if (pick < 97) add_frame(1'b1, 1'b0);
      else add_frame(1'b0, 1'b1);
      send_queued();
    end
    byte_if.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d bytes sent, %0d pulse words checked, %0d of them from new frames",
             n_bytes, sb.words, sb.pushes);
    $display("tb: covered stray and empty frames, signs, white space, saturation, stalls");
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
